FILE: sv/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
`default_nettype none

package bpa_pkg;

  localparam int WORD_W     = 32;
  localparam int OFF_W      = 5;
  localparam int OP_W       = 2;
  localparam int PAGE_W     = 13;
  localparam int INDEX_W    = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_ALLOC_EXAM,
    ST_HINT_SCAN,
    ST_HINT_FETCH,
    ST_HINT_EXAM,
    ST_PAGE_EXAM,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic adv;
    logic use_held;
    logic alloc_take;
    logic hint_take;
    logic free_take;
    logic query_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            hint_oob;
    logic            page_oob;
    logic            found;
    logic            last;
    logic            out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: sv/bitmap_page_allocator.sv
// Allocate fetches and examines one 32-bit bitmap word at a time from the hint until a free page
// is found, then scans on for the next free page as the new hint; free and query fetch one word.
// Throughput: one request at a time, set by the single-port bitmap word memory scan; the next
// transfer is taken as the result turns valid, so a request holds the input only through its own
// fetch, examine and scan states, longer only while a previous result still waits on the output.
// Reset: synchronous; afterwards a clearing pass writes one bitmap word per cycle,
// covering all (MAX_PAGES + 31) / 32 words, before the first request is taken.
`default_nettype none

module bitmap_page_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [1:0] operation, [14:2] page_index, [15] zero
  input  wire logic [bpa_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [0] ok, [12:1] allocated_index, [15:13] zero
  output logic [bpa_pkg::OUT_DATA_W-1:0]         m_tdata
);

  bpa_pkg::cmd_t    cmd;
  bpa_pkg::status_t status;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bpa_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Only one request is in flight: a transfer closes the input until its result is out.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a request is in flight");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !status.out_busy)
    else $error("result register loaded while still waiting");

  // A page is only taken when a free bit was found and the bitmap is not full.
  a_alloc_legal: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_take |-> (status.found && !status.full))
    else $error("allocation without a free page");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.alloc_take, cmd.free_take, cmd.query_take}))
    else $error("conflicting bitmap commands");

endmodule

`default_nettype wire

FILE: sv/bpa_ctrl.sv
// Sequencer for the allocator: clearing pass, word scans and result hand-off.
`default_nettype none

module bpa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire bpa_pkg::status_t status,
  output bpa_pkg::cmd_t         cmd
);

  bpa_pkg::state_t state;
  bpa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bpa_pkg::ST_CLEAR: begin
        if (status.last) state_next = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = bpa_pkg::ST_FETCH;
      end
      bpa_pkg::ST_FETCH: begin
        case (status.op)
          bpa_pkg::OP_ALLOC: begin
            if (status.full || status.hint_oob) state_next = bpa_pkg::ST_RESP;
            else state_next = bpa_pkg::ST_ALLOC_EXAM;
          end
          bpa_pkg::OP_FREE, bpa_pkg::OP_QUERY: begin
            if (status.page_oob) state_next = bpa_pkg::ST_RESP;
            else state_next = bpa_pkg::ST_PAGE_EXAM;
          end
          default: state_next = bpa_pkg::ST_RESP;
        endcase
      end
      bpa_pkg::ST_ALLOC_EXAM: begin
        if (status.found) state_next = bpa_pkg::ST_HINT_SCAN;
        else if (status.last) state_next = bpa_pkg::ST_RESP;
        else state_next = bpa_pkg::ST_FETCH;
      end
      bpa_pkg::ST_HINT_SCAN, bpa_pkg::ST_HINT_EXAM: begin
        if (status.found || status.last) state_next = bpa_pkg::ST_RESP;
        else state_next = bpa_pkg::ST_HINT_FETCH;
      end
      bpa_pkg::ST_HINT_FETCH: begin
        state_next = bpa_pkg::ST_HINT_EXAM;
      end
      bpa_pkg::ST_PAGE_EXAM: begin
        state_next = bpa_pkg::ST_RESP;
      end
      bpa_pkg::ST_RESP: begin
        if (!status.out_busy) state_next = bpa_pkg::ST_IDLE;
      end
      default: state_next = bpa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      bpa_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.adv    = !status.last;
      end
      bpa_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      bpa_pkg::ST_ALLOC_EXAM: begin
        cmd.alloc_take = status.found;
        cmd.adv        = !status.found && !status.last;
      end
      bpa_pkg::ST_HINT_SCAN: begin
        cmd.use_held  = 1'b1;
        cmd.hint_take = status.found || status.last;
        cmd.adv       = !status.found && !status.last;
      end
      bpa_pkg::ST_HINT_EXAM: begin
        cmd.hint_take = status.found || status.last;
        cmd.adv       = !status.found && !status.last;
      end
      bpa_pkg::ST_PAGE_EXAM: begin
        cmd.free_take  = (status.op == bpa_pkg::OP_FREE);
        cmd.query_take = (status.op == bpa_pkg::OP_QUERY);
      end
      bpa_pkg::ST_RESP: begin
        cmd.out_load = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bpa_datapath.sv
// Bitmap word memory, free-bit search, hint and count registers, output register.
`default_nettype none

module bpa_datapath #(
  parameter int MAX_PAGES = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bpa_pkg::cmd_t                       cmd,
  output bpa_pkg::status_t                         status,
  input  wire logic [bpa_pkg::IN_DATA_W-1:0]       s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [bpa_pkg::OUT_DATA_W-1:0]           m_tdata
);

  localparam int WORD_W = bpa_pkg::WORD_W;
  localparam int OFF_W  = bpa_pkg::OFF_W;
  localparam int NWORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int TAIL   = MAX_PAGES - (NWORDS - 1) * WORD_W;
  localparam int FP_W   = WA_W + OFF_W;

  logic [WORD_W-1:0]             bitmap [NWORDS];
  logic [WORD_W-1:0]             rdata;
  logic [WORD_W-1:0]             held;
  logic [WA_W-1:0]               word_ptr;
  logic [OFF_W:0]                scan_off;
  logic [bpa_pkg::OP_W-1:0]      op_r;
  logic [bpa_pkg::PAGE_W-1:0]    page_r;
  logic [CNT_W-1:0]              hint;
  logic [CNT_W-1:0]              count;
  logic                          res_ok;
  logic [bpa_pkg::INDEX_W-1:0]   res_idx;
  logic                          out_ok;
  logic [bpa_pkg::INDEX_W-1:0]   out_idx;

  logic [bpa_pkg::OP_W-1:0]      in_op;
  logic [bpa_pkg::PAGE_W-1:0]    in_page;
  logic                          last;
  logic [WORD_W-1:0]             src;
  logic [WORD_W-1:0]             free_vec;
  logic [OFF_W-1:0]              ffz;
  logic                          found;
  logic [CNT_W-1:0]              found_page;
  logic [WORD_W-1:0]             take_bit;
  logic                          page_bit;
  logic                          free_ok;
  logic                          wr_en;
  logic [WORD_W-1:0]             wr_data;

  assign in_op   = s_tdata[bpa_pkg::OP_W-1:0];
  assign in_page = s_tdata[bpa_pkg::OP_W +: bpa_pkg::PAGE_W];

  assign last = (word_ptr == WA_W'(NWORDS - 1));
  assign src  = cmd.use_held ? held : rdata;

  // Free bits at or after the scan offset; pages past the end count as taken.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      free_vec[j] = !src[j] && ((OFF_W + 1)'(j) >= scan_off) && (!last || j < TAIL);
    end
  end

  always_comb begin
    ffz = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_vec[j]) ffz = OFF_W'(j);
    end
  end

  assign found      = |free_vec;
  assign found_page = CNT_W'(FP_W'({word_ptr, ffz}));
  assign take_bit   = WORD_W'(1) << ffz;
  assign page_bit   = rdata[page_r[OFF_W-1:0]];
  assign free_ok    = cmd.free_take && page_bit;

  assign wr_en = cmd.clr_wr || cmd.alloc_take || free_ok;

  always_comb begin
    if (cmd.clr_wr) begin
      wr_data = '0;
    end else if (cmd.alloc_take) begin
      wr_data = rdata | take_bit;
    end else begin
      wr_data = rdata & ~(WORD_W'(1) << page_r[OFF_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[word_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= bitmap[word_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_ptr <= '0;
    end else if (cmd.load) begin
      if (in_op == bpa_pkg::OP_ALLOC) begin
        word_ptr <= WA_W'(hint >> OFF_W);
      end else begin
        word_ptr <= WA_W'(in_page >> OFF_W);
      end
    end else if (cmd.adv) begin
      word_ptr <= WA_W'(word_ptr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      page_r  <= in_page;
      res_ok  <= 1'b0;
      res_idx <= '0;
      if (in_op == bpa_pkg::OP_ALLOC) begin
        scan_off <= (OFF_W + 1)'(OFF_W'(hint));
      end else begin
        scan_off <= '0;
      end
    end else begin
      if (cmd.adv) begin
        scan_off <= '0;
      end
      if (cmd.alloc_take) begin
        held     <= rdata | take_bit;
        scan_off <= (OFF_W + 1)'(ffz) + 1'b1;
        res_ok   <= 1'b1;
        res_idx  <= bpa_pkg::INDEX_W'(found_page);
      end
      if (free_ok) begin
        res_ok <= 1'b1;
      end
      if (cmd.query_take) begin
        res_ok <= !page_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hint  <= '0;
      count <= '0;
    end else begin
      if (cmd.alloc_take) begin
        count <= CNT_W'(count + 1'b1);
      end else if (free_ok && count != '0) begin
        count <= CNT_W'(count - 1'b1);
      end
      if (cmd.hint_take) begin
        hint <= found ? found_page : CNT_W'(MAX_PAGES);
      end else if (free_ok && 32'(page_r) < 32'(hint)) begin
        hint <= CNT_W'(page_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok  <= res_ok;
      out_idx <= res_idx;
    end
  end

  assign m_tdata = {{(bpa_pkg::OUT_DATA_W - bpa_pkg::INDEX_W - 1){1'b0}}, out_idx, out_ok};

  always_comb begin
    status.op       = op_r;
    status.full     = (32'(count) >= MAX_PAGES);
    status.hint_oob = (32'(hint) >= MAX_PAGES);
    status.page_oob = (32'(page_r) >= MAX_PAGES);
    status.found    = found;
    status.last     = last;
    status.out_busy = m_tvalid && !m_tready;
  end

endmodule

`default_nettype wire
